@@ hdl/pnfe_pkg.sv @@
`default_nettype none

package pnfe_pkg;

    // Default sizes of the net
    localparam int PLACE_COUNT_DEF      = 16;
    localparam int TRANSITION_COUNT_DEF = 16;
    localparam int WEIGHT_MAX_DEF       = 255;
    localparam int TOKEN_MAX_DEF        = 65535;

    // Field widths fixed by the word format
    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 4;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int TOKEN_W  = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET_IN_WEIGHT  = 3'd0,
        OP_SET_OUT_WEIGHT = 3'd1,
        OP_SET_TOKENS     = 3'd2,
        OP_FIRE           = 3'd3,
        OP_TEST           = 3'd4,
        OP_READ_TOKENS    = 3'd5
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_NOT_ENABLED = 2'd1,
        ST_WEIGHT_HIGH = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

`default_nettype wire

@@ hdl/pnfe_place_lanes.sv @@
`default_nettype none

module pnfe_place_lanes
    import pnfe_pkg::*;
#(
    parameter int PLACE_COUNT = PLACE_COUNT_DEF,
    parameter int WEIGHT_W    = 8,
    parameter int TOKEN_MAX   = TOKEN_MAX_DEF
) (
    input  wire logic [PLACE_COUNT-1:0][TOKEN_W-1:0]  i_marking,
    input  wire logic [PLACE_COUNT-1:0][WEIGHT_W-1:0] i_in_row,
    input  wire logic [PLACE_COUNT-1:0][WEIGHT_W-1:0] i_out_row,
    output logic                                      o_all_covered,
    output logic      [PLACE_COUNT-1:0][TOKEN_W-1:0]  o_fired
);

    logic [PLACE_COUNT-1:0] covered;

    // Compare and update every place in its own lane
    always_comb begin
        for (int p = 0; p < PLACE_COUNT; p++) begin
            logic [TOKEN_W-1:0] w_in;
            logic [TOKEN_W-1:0] w_out;
            logic [TOKEN_W:0]   sum;
            w_in  = TOKEN_W'(i_in_row[p]);
            w_out = TOKEN_W'(i_out_row[p]);
            covered[p] = (i_marking[p] >= w_in);
            // no borrow when the transition is enabled
            sum = {1'b0, i_marking[p]} - {1'b0, w_in} + {1'b0, w_out};
            if (32'(sum) > TOKEN_MAX) begin
                o_fired[p] = TOKEN_W'(TOKEN_MAX);
            end else begin
                o_fired[p] = sum[TOKEN_W-1:0];
            end
        end
    end

    // Enabled only when every place holds its input weight
    assign o_all_covered = &covered;

endmodule

`default_nettype wire

@@ hdl/petri_net_firing_engine_core.sv @@
// Place/transition net firing engine.
// Input channel: i_in_valid / o_in_stall carry one command word (opcode, place,
// transition, value). Output channel: o_out_valid / i_out_stall carry one
// result word (enabled, status, tokens) per command.
// In idle, the edge that accepts the word reads the transition's weight column
// from both arc memories; in execute, the commit edge compares and updates
// all place counters in parallel and, for a weight command, writes the column
// back. The result word is registered on the commit edge, which a held output
// word can delay; a new command is accepted only in idle, once the previous
// one has committed, as set by the read-modify-write of the weight memories.
// While the receiver stalls, one further command is accepted; it waits in
// execute with its column read until the output register is taken.
// Reset (i_rst_n low, synchronous) clears all token counts and the column
// valid bits, so every arc weight reads zero at once; no clearing pass is
// needed and a command may be accepted on the first cycle after reset.
`default_nettype none

module petri_net_firing_engine_core
    import pnfe_pkg::*;
#(
    parameter int PLACE_COUNT      = PLACE_COUNT_DEF,
    parameter int TRANSITION_COUNT = TRANSITION_COUNT_DEF,
    parameter int WEIGHT_MAX       = WEIGHT_MAX_DEF,
    parameter int TOKEN_MAX        = TOKEN_MAX_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire logic [INDEX_W-1:0]  i_place_index,
    input  wire logic [INDEX_W-1:0]  i_transition_index,
    input  wire logic [VALUE_W-1:0]  i_value,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_enabled,
    output logic [STATUS_W-1:0]      o_status,
    output logic [TOKEN_W-1:0]       o_tokens
);

    localparam int WW = $clog2(WEIGHT_MAX + 1);
    localparam int PW = $clog2(PLACE_COUNT);
    localparam int TW = $clog2(TRANSITION_COUNT);

    t_state r_state, n_state;

    logic [OPCODE_W-1:0] r_op;
    logic [INDEX_W-1:0]  r_p;
    logic [INDEX_W-1:0]  r_t;
    logic [VALUE_W-1:0]  r_value;

    logic [PLACE_COUNT-1:0][WW-1:0] r_iw_mem [TRANSITION_COUNT];
    logic [PLACE_COUNT-1:0][WW-1:0] r_ow_mem [TRANSITION_COUNT];
    logic [PLACE_COUNT-1:0][WW-1:0] r_iw_rd, r_ow_rd;
    logic [TRANSITION_COUNT-1:0]    r_iw_vld, r_ow_vld;

    logic [PLACE_COUNT-1:0][TOKEN_W-1:0] r_marking, n_marking;

    logic                r_out_valid;
    logic                r_enabled, n_enabled;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [TOKEN_W-1:0]  r_tokens, n_tokens;

    logic                           accept;
    logic                           commit;
    logic [TW-1:0]                  rd_addr;
    logic [TW-1:0]                  t_addr;
    logic [PW-1:0]                  p_addr;
    logic                           p_ok;
    logic                           t_ok;
    logic [PLACE_COUNT-1:0][WW-1:0] iw_row, ow_row;
    logic [PLACE_COUNT-1:0][WW-1:0] n_row;
    logic                           iw_we, ow_we;
    logic                           all_covered;
    logic                           trans_en;
    logic [PLACE_COUNT-1:0][TOKEN_W-1:0] fired;

    assign accept = i_in_valid && !o_in_stall;
    assign t_addr = TW'(r_t);
    assign p_addr = PW'(r_p);
    assign p_ok   = (32'(r_p) < PLACE_COUNT);
    assign t_ok   = (32'(r_t) < TRANSITION_COUNT);

    // Sequence each word through read and execute
    always_comb begin
        n_state    = r_state;
        commit     = 1'b0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || !i_out_stall) begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the command word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_opcode;
            r_p     <= i_place_index;
            r_t     <= i_transition_index;
            r_value <= i_value;
        end
    end

    // Read the column of the new word, or keep the held one
    assign rd_addr = (r_state == S_IDLE) ? TW'(i_transition_index) : t_addr;

    always_ff @(posedge i_clk) begin
        r_iw_rd <= r_iw_mem[rd_addr];
        r_ow_rd <= r_ow_mem[rd_addr];
        if (iw_we) begin
            r_iw_mem[t_addr] <= n_row;
        end
        if (ow_we) begin
            r_ow_mem[t_addr] <= n_row;
        end
    end

    // Columns never written read as no arcs
    assign iw_row = r_iw_vld[t_addr] ? r_iw_rd : '0;
    assign ow_row = r_ow_vld[t_addr] ? r_ow_rd : '0;

    pnfe_place_lanes #(
        .PLACE_COUNT (PLACE_COUNT),
        .WEIGHT_W    (WW),
        .TOKEN_MAX   (TOKEN_MAX)
    ) u_lanes (
        .i_marking     (r_marking),
        .i_in_row      (iw_row),
        .i_out_row     (ow_row),
        .o_all_covered (all_covered),
        .o_fired       (fired)
    );

    assign trans_en = t_ok && all_covered;

    // Decode the command and form the write-back and result
    always_comb begin
        n_marking = r_marking;
        n_enabled = 1'b0;
        n_status  = ST_OK;
        iw_we     = 1'b0;
        ow_we     = 1'b0;
        n_row     = (r_op == OP_SET_IN_WEIGHT) ? iw_row : ow_row;
        if (p_ok) begin
            n_row[p_addr] = WW'(r_value);
        end
        unique case (r_op) inside
            OP_SET_IN_WEIGHT, OP_SET_OUT_WEIGHT: begin
                if (32'(r_value) > WEIGHT_MAX) begin
                    n_status = ST_WEIGHT_HIGH;
                end else if (p_ok && t_ok) begin
                    iw_we = commit && (r_op == OP_SET_IN_WEIGHT);
                    ow_we = commit && (r_op == OP_SET_OUT_WEIGHT);
                end
            end
            OP_SET_TOKENS: begin
                if (p_ok) begin
                    if (32'(r_value) > TOKEN_MAX) begin
                        n_marking[p_addr] = TOKEN_W'(TOKEN_MAX);
                    end else begin
                        n_marking[p_addr] = TOKEN_W'(r_value);
                    end
                end
            end
            OP_FIRE: begin
                if (trans_en) begin
                    n_enabled = 1'b1;
                    n_marking = fired;
                end else begin
                    n_status = ST_NOT_ENABLED;
                end
            end
            OP_TEST: begin
                n_enabled = trans_en;
            end
            default: begin
                // read tokens and the unused codes change nothing
            end
        endcase
        n_tokens = p_ok ? n_marking[p_addr] : '0;
    end

    // Update marking and column valid bits on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marking <= '0;
            r_iw_vld  <= '0;
            r_ow_vld  <= '0;
        end else if (commit) begin
            r_marking <= n_marking;
            if (iw_we) begin
                r_iw_vld[t_addr] <= 1'b1;
            end
            if (ow_we) begin
                r_ow_vld[t_addr] <= 1'b1;
            end
        end
    end

    // Hold the result word until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_enabled <= n_enabled;
            r_status  <= n_status;
            r_tokens  <= n_tokens;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_enabled   = r_enabled;
    assign o_status    = r_status;
    assign o_tokens    = r_tokens;

    // Checks
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted word did not enter execute");

    a_commit_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_out_valid)
        else $error("committed word not presented");

    a_enabled_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_enabled) |-> (o_status == ST_OK))
        else $error("enabled result with error status");

    a_weight_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (n_status == ST_WEIGHT_HIGH)) |-> (!iw_we && !ow_we))
        else $error("oversized weight written to memory");

endmodule

`default_nettype wire

@@ dv/petri_net_firing_engine_core_test.sv @@
`default_nettype none

module petri_net_firing_engine_core_test;
    import pnfe_pkg::*;

    localparam int NET_PLACES      = PLACE_COUNT_DEF;
    localparam int NET_TRANSITIONS = TRANSITION_COUNT_DEF;
    localparam int RANDOM_WORDS    = 1000;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_AFTER      = 400;
    localparam int HOLD_CYCLES     = 300;

    // Opcodes outside the enum; the block treats them as a token read
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [INDEX_W-1:0]  place;
        logic [INDEX_W-1:0]  trans;
        logic [VALUE_W-1:0]  value;
    } t_net_cmd;

    typedef struct packed {
        logic               enabled;
        t_status            status;
        logic [TOKEN_W-1:0] tokens;
    } t_net_result;

    logic                i_clk              = 1'b0;
    logic                i_rst_n            = 1'b0;
    logic                i_in_valid         = 1'b0;
    logic [OPCODE_W-1:0] i_opcode           = '0;
    logic [INDEX_W-1:0]  i_place_index      = '0;
    logic [INDEX_W-1:0]  i_transition_index = '0;
    logic [VALUE_W-1:0]  i_value            = '0;
    logic                i_out_stall        = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_enabled;
    logic [STATUS_W-1:0] o_status;
    logic [TOKEN_W-1:0]  o_tokens;

    petri_net_firing_engine_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_place_index      (i_place_index),
        .i_transition_index (i_transition_index),
        .i_value            (i_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_enabled          (o_enabled),
        .o_status           (o_status),
        .o_tokens           (o_tokens)
    );

    // Shadow copy of the net
    logic [7:0]         in_arc  [NET_PLACES][NET_TRANSITIONS];
    logic [7:0]         out_arc [NET_PLACES][NET_TRANSITIONS];
    logic [TOKEN_W-1:0] marking [NET_PLACES];

    t_net_cmd    pending_cmds[$];
    t_net_result expected_results[$];

    int     error_count   = 0;
    int     words_sent    = 0;
    int     results_taken = 0;
    int     cycle_count   = 0;
    int     send_gap      = 0;
    int     recv_wait     = 0;
    int     hold_left     = 0;
    logic   hold_done     = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Apply one command to the shadow net and return the word it produces
    function automatic t_net_result apply_command(t_net_cmd cmd);
        t_net_result res;
        logic        live;
        int          level;
        res = '{enabled: 1'b0, status: ST_OK, tokens: '0};
        live = 1'b1;
        for (int p = 0; p < NET_PLACES; p++) begin
            if (marking[p] < in_arc[p][cmd.trans]) live = 1'b0;
        end
        case (cmd.op) inside
            OP_SET_IN_WEIGHT, OP_SET_OUT_WEIGHT: begin
                if (cmd.value > WEIGHT_MAX_DEF) begin
                    res.status = ST_WEIGHT_HIGH;
                end else if (cmd.op == OP_SET_IN_WEIGHT) begin
                    in_arc[cmd.place][cmd.trans] = cmd.value[7:0];
                end else begin
                    out_arc[cmd.place][cmd.trans] = cmd.value[7:0];
                end
            end
            OP_SET_TOKENS: begin
                marking[cmd.place] = cmd.value;
            end
            OP_FIRE: begin
                if (live) begin
                    res.enabled = 1'b1;
                    for (int p = 0; p < NET_PLACES; p++) begin
                        level = int'(marking[p]) - int'(in_arc[p][cmd.trans])
                              + int'(out_arc[p][cmd.trans]);
                        if (level > TOKEN_MAX_DEF) level = TOKEN_MAX_DEF;
                        marking[p] = level[TOKEN_W-1:0];
                    end
                end else begin
                    res.status = ST_NOT_ENABLED;
                end
            end
            OP_TEST: begin
                res.enabled = live;
            end
            default: ;
        endcase
        res.tokens = marking[cmd.place];
        return res;
    endfunction

    task automatic queue_cmd(input logic [OPCODE_W-1:0] op, input int place,
                             input int trans, input int value);
        t_net_cmd cmd;
        cmd.op    = op;
        cmd.place = place[INDEX_W-1:0];
        cmd.trans = trans[INDEX_W-1:0];
        cmd.value = value[VALUE_W-1:0];
        pending_cmds.insert(pending_cmds.size(), cmd);
    endtask

    // Idle cycles before a word; every fourth stretch of 50 runs back to back
    function automatic int draw_idle(int n);
        if ((n / 50) % 4 == 3) return 0;
        return $urandom_range(0, 15);
    endfunction

    // Sender: hold a stalled word, otherwise advance to the next after its gap
    always @(posedge i_clk) begin
        t_net_cmd seen;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                seen.op    = i_opcode;
                seen.place = i_place_index;
                seen.trans = i_transition_index;
                seen.value = i_value;
                expected_results.insert(expected_results.size(), apply_command(seen));
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (send_gap != 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    t_net_cmd nxt;
                    nxt = pending_cmds.pop_front();
                    i_opcode           <= nxt.op;
                    i_place_index      <= nxt.place;
                    i_transition_index <= nxt.trans;
                    i_value            <= nxt.value;
                    i_in_valid         <= 1'b1;
                    words_sent         <= words_sent + 1;
                    send_gap           <= draw_idle(words_sent);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result word, then stall for a drawn number of cycles
    always @(posedge i_clk) begin
        t_net_result want;
        int          next_wait;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_wait   <= 0;
        end else begin
            next_wait = (recv_wait > 0) ? recv_wait - 1 : 0;
            if (o_out_valid && !i_out_stall) begin
                results_taken <= results_taken + 1;
                if (expected_results.size() == 0) begin
                    error_count <= error_count + 1;
                    $display("%0t: unexpected word enabled=%0b status=%0d tokens=%0d",
                             $time, o_enabled, o_status, o_tokens);
                end else begin
                    want = expected_results.pop_front();
                    if (o_enabled !== want.enabled || o_status !== want.status ||
                        o_tokens !== want.tokens) begin
                        error_count <= error_count + 1;
                        $display("%0t: exp en=%0b st=%0d tok=%0d got en=%0b st=%0d tok=%0d",
                                 $time, want.enabled, want.status, want.tokens,
                                 o_enabled, o_status, o_tokens);
                    end
                end
                next_wait = draw_idle(results_taken);
            end
            recv_wait   <= next_wait;
            i_out_stall <= (next_wait != 0) || (hold_left != 0);
        end
    end

    // Long receiver hold-off once, so the block fills and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && results_taken >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Guard against a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("petri_net_firing_engine_core: mismatch");
            $finish;
        end
    end

    initial begin
        int r;
        int op_pick;
        int val;
        logic [OPCODE_W-1:0] op;

        for (int p = 0; p < NET_PLACES; p++) begin
            marking[p] = '0;
            for (int t = 0; t < NET_TRANSITIONS; t++) begin
                in_arc[p][t]  = '0;
                out_arc[p][t] = '0;
            end
        end

        // Directed: empty net, weight limits, refusal, saturation, spare opcodes
        queue_cmd(OP_READ_TOKENS,    0, 0, 0);
        queue_cmd(OP_TEST,           0, 0, 0);
        queue_cmd(OP_FIRE,           3, 0, 0);
        queue_cmd(OP_SET_IN_WEIGHT,  0, 1, 255);
        queue_cmd(OP_SET_IN_WEIGHT,  1, 1, 256);
        queue_cmd(OP_SET_OUT_WEIGHT, 2, 1, 65535);
        queue_cmd(OP_FIRE,           0, 1, 0);
        queue_cmd(OP_SET_TOKENS,     0, 0, 65535);
        queue_cmd(OP_TEST,           0, 1, 0);
        queue_cmd(OP_SET_OUT_WEIGHT, 15, 1, 255);
        queue_cmd(OP_SET_TOKENS,     15, 0, 65400);
        queue_cmd(OP_FIRE,           15, 1, 0);
        queue_cmd(OP_READ_TOKENS,    0, 0, 0);
        queue_cmd(OP_SET_IN_WEIGHT,  0, 1, 0);
        queue_cmd(OP_TEST,           0, 1, 0);
        queue_cmd(OP_SET_TOKENS,     3, 0, 16'hAAAA);
        queue_cmd(OP_SET_TOKENS,     4, 0, 16'h5555);
        queue_cmd(OP_SPARE_LO,       3, 7, 16'hFFFF);
        queue_cmd(OP_SPARE_HI,       4, 8, 16'h1234);
        queue_cmd(OP_SET_OUT_WEIGHT, 0, 15, 1);
        queue_cmd(OP_SET_IN_WEIGHT,  15, 15, 255);
        queue_cmd(OP_FIRE,           0, 15, 0);
        queue_cmd(OP_SET_TOKENS,     15, 0, 254);
        queue_cmd(OP_FIRE,           15, 15, 0);
        queue_cmd(OP_READ_TOKENS,    15, 0, 0);

        // Random: mostly small weights and counts so transitions often fire
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            op_pick = $urandom_range(0, 99);
            r = $urandom_range(0, 99);
            if (op_pick < 12) op = OP_SET_IN_WEIGHT;
            else if (op_pick < 22) op = OP_SET_OUT_WEIGHT;
            else if (op_pick < 34) op = OP_SET_TOKENS;
            else if (op_pick < 64) op = OP_FIRE;
            else if (op_pick < 82) op = OP_TEST;
            else if (op_pick < 92) op = OP_READ_TOKENS;
            else if (op_pick < 96) op = OP_SPARE_LO;
            else op = OP_SPARE_HI;
            if (op == OP_SET_IN_WEIGHT || op == OP_SET_OUT_WEIGHT) begin
                if (r < 45) val = 0;
                else if (r < 80) val = $urandom_range(1, 3);
                else if (r < 92) val = $urandom_range(0, 255);
                else val = $urandom_range(0, 65535);
            end else if (op == OP_SET_TOKENS) begin
                if (r < 65) val = $urandom_range(0, 12);
                else if (r < 85) val = $urandom_range(0, 65535);
                else val = 65535 - $urandom_range(0, 300);
            end else begin
                val = $urandom_range(0, 65535);
            end
            queue_cmd(op, $urandom_range(0, 15), $urandom_range(0, 15), val);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all words sent, all results back, then a short settle
        while (pending_cmds.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0) begin
            $display("petri_net_firing_engine_core: match");
        end else begin
            $display("petri_net_firing_engine_core: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
